// File: rtl/core/bpc_pkg.sv
// Package with the shared constants and codes of the button press classifier.
`timescale 1ns / 1ps
package bpc_pkg;

  // Default timestamp width in bits.
  localparam int unsigned StampBits = 48;

  // Threshold registers are kept in milliseconds and also as microseconds.
  localparam int unsigned MsW      = 16;
  localparam int unsigned UsPerMs  = 1000;
  localparam int unsigned UsW      = 26;  // 65535 * 1000 fits in 26 bits

  localparam logic [MsW-1:0] LongPressMsReset   = 16'd1000;
  localparam logic [MsW-1:0] DoublePressMsReset = 16'd300;

  // Configuration port.
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic RegLongPress   = 1'b0;  // paddr bit 2 clear: byte address 0
  localparam logic RegDoublePress = 1'b1;  // paddr bit 2 set: byte address 4

  // Gesture codes on the result stream.
  localparam int unsigned GestW = 2;
  localparam logic [GestW-1:0] GestShort  = 2'd0;
  localparam logic [GestW-1:0] GestLong   = 2'd1;
  localparam logic [GestW-1:0] GestDouble = 2'd2;

  localparam int unsigned OutW = 8;

  // Width of a byte-padded input word for a given timestamp width.
  function automatic int unsigned in_width(input int unsigned stamp_bits);
    return ((stamp_bits + 1 + 7) / 8) * 8;
  endfunction

endpackage

// File: rtl/core/button_press_classifier_core.sv
// Top level of the button press classifier: input register, gesture state machine, result register.
`timescale 1ns / 1ps
// The block takes one poll sample per word on the slave stream (button level in bit 0 and the
// free-running microsecond timestamp above it) and emits a one-word result on the master stream
// whenever a gesture is recognized: short press, long press or double press. A press held for at
// least the long-press threshold gives a long press, reported as soon as the hold reaches that
// length, even while the button is still down. A shorter press is held back for the double-press
// window after release; a second press in that window gives a double press, and a release window
// that runs out gives a short press. Elapsed time is computed modulo 2^STAMP_BITS, so a timestamp
// that wraps reads correctly, and one that runs backwards reads as a long elapsed time. Most
// samples produce no result word. Each sample is registered in the input register and its result,
// if any, in the output register; a new sample is accepted in every cycle as long as the result
// side keeps up, so the sustained rate is one sample per clock. The only thing that stops intake
// is a result word that the downstream side has not taken: the sample behind it then waits in the
// input register, and the slave side stalls once that register is full. The thresholds are
// written over the APB port at byte addresses 0 (long-press threshold) and 4 (double-press
// window), both in milliseconds, and are converted to microseconds once, at the write, so the
// per-sample path is a subtract and a compare. Write the thresholds only while the stream is idle.
module button_press_classifier_core #(
  parameter int unsigned STAMP_BITS = bpc_pkg::StampBits
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Sample stream.
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: [0] button_down, [STAMP_BITS:1] time_us, zero padding above.
  input  logic [bpc_pkg::in_width(STAMP_BITS)-1:0] s_axis_tdata,
  // Gesture stream.
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // tdata: [1:0] gesture, zero padding above.
  output logic [bpc_pkg::OutW-1:0]                 m_axis_tdata,
  // Configuration port.
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [bpc_pkg::AddrW-1:0]                paddr,
  input  logic [bpc_pkg::DataW-1:0]                pwdata,
  output logic [bpc_pkg::DataW-1:0]                prdata,
  output logic                                     pready
);
  import bpc_pkg::*;

  // Compare width covers both the elapsed time and the threshold in microseconds.
  localparam int unsigned CmpW = (STAMP_BITS > UsW) ? STAMP_BITS : UsW;

  // Phase codes of the gesture state machine.
  localparam logic [1:0] PhIdle        = 2'd0;
  localparam logic [1:0] PhPressed     = 2'd1;
  localparam logic [1:0] PhWaitRelease = 2'd2;
  localparam logic [1:0] PhWaitDouble  = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers. The microsecond copy is what the datapath uses.
  // ---------------------------------------------------------------------------
  logic [MsW-1:0] long_ms_q, long_ms_d;
  logic [MsW-1:0] double_ms_q, double_ms_d;
  logic [UsW-1:0] long_us_q, long_us_d;
  logic [UsW-1:0] double_us_q, double_us_d;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    long_ms_d   = long_ms_q;
    double_ms_d = double_ms_q;
    long_us_d   = long_us_q;
    double_us_d = double_us_q;
    if (cfg_wr) begin
      case (paddr[2])
        RegLongPress: begin
          long_ms_d = pwdata[MsW-1:0];
          long_us_d = UsW'(pwdata[MsW-1:0]) * UsW'(UsPerMs);
        end
        RegDoublePress: begin
          double_ms_d = pwdata[MsW-1:0];
          double_us_d = UsW'(pwdata[MsW-1:0]) * UsW'(UsPerMs);
        end
        default: begin
          long_ms_d = long_ms_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms_q   <= LongPressMsReset;
      double_ms_q <= DoublePressMsReset;
      long_us_q   <= UsW'(LongPressMsReset) * UsW'(UsPerMs);
      double_us_q <= UsW'(DoublePressMsReset) * UsW'(UsPerMs);
    end else begin
      long_ms_q   <= long_ms_d;
      double_ms_q <= double_ms_d;
      long_us_q   <= long_us_d;
      double_us_q <= double_us_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegLongPress:   prdata = DataW'(long_ms_q);
      RegDoublePress: prdata = DataW'(double_ms_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. A sample moves on to the state machine whenever the result
  // register is free or is being emptied in the same cycle.
  // ---------------------------------------------------------------------------
  logic                  in_vld_q, in_vld_d;
  logic                  down_q;
  logic [STAMP_BITS-1:0] now_q;
  logic                  advance;
  logic                  out_vld_q, out_vld_d;
  logic [GestW-1:0]      gest_q;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      down_q <= s_axis_tdata[0];
      now_q  <= s_axis_tdata[STAMP_BITS:1];
    end
  end

  // ---------------------------------------------------------------------------
  // Gesture state machine. Elapsed times wrap naturally in STAMP_BITS bits.
  // ---------------------------------------------------------------------------
  logic [1:0]            phase_q, phase_d;
  logic [STAMP_BITS-1:0] press_q, press_d;
  logic [STAMP_BITS-1:0] release_q, release_d;
  logic [STAMP_BITS-1:0] held_us;
  logic [STAMP_BITS-1:0] gap_us;
  logic                  long_hit;
  logic                  gap_hit;
  logic                  fire;
  logic [GestW-1:0]      gest_d;

  assign held_us  = now_q - press_q;
  assign gap_us   = now_q - release_q;
  assign long_hit = CmpW'(held_us) >= CmpW'(long_us_q);
  assign gap_hit  = CmpW'(gap_us) >= CmpW'(double_us_q);

  always_comb begin
    phase_d   = phase_q;
    press_d   = press_q;
    release_d = release_q;
    fire      = 1'b0;
    gest_d    = GestShort;
    case (phase_q)
      PhIdle: begin
        if (down_q) begin
          press_d = now_q;
          phase_d = PhPressed;
        end
      end
      PhPressed: begin
        // A long hold wins over a release seen in the same sample.
        if (long_hit) begin
          fire    = 1'b1;
          gest_d  = GestLong;
          phase_d = down_q ? PhWaitRelease : PhIdle;
        end else if (!down_q) begin
          release_d = now_q;
          phase_d   = PhWaitDouble;
        end
      end
      PhWaitRelease: begin
        if (!down_q) begin
          phase_d = PhIdle;
        end
      end
      PhWaitDouble: begin
        // Any press in this phase counts; the window is only checked while released.
        if (down_q) begin
          fire    = 1'b1;
          gest_d  = GestDouble;
          phase_d = PhWaitRelease;
        end else if (gap_hit) begin
          fire    = 1'b1;
          gest_d  = GestShort;
          phase_d = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      press_q   <= '0;
      release_q <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      press_q   <= press_d;
      release_q <= release_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fire) begin
      gest_q <= gest_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'(gest_q);

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the button press classifier: gesture prediction and stream checks.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned StampW       = bpc_pkg::StampBits;
  localparam int unsigned SampleW      = bpc_pkg::in_width(StampW);
  localparam int unsigned QuietLimit   = 400;  // cycles with no word moving on either stream
  localparam int unsigned SettleCycles = 6;    // a sample and its result pass two registers
  localparam int unsigned PhaseSamples = 130;

  localparam logic [bpc_pkg::AddrW-1:0] LongPressAddr   = {bpc_pkg::RegLongPress, 2'b00};
  localparam logic [bpc_pkg::AddrW-1:0] DoublePressAddr = {bpc_pkg::RegDoublePress, 2'b00};

  typedef logic [StampW-1:0]          stamp_t;
  typedef logic [bpc_pkg::GestW-1:0] gesture_t;
  typedef struct packed {
    logic   down;
    stamp_t stamp;
  } sample_t;

  // The predictor walks the same four phases as the block.
  typedef enum logic [1:0] {
    PhIdle,
    PhPressed,
    PhHeld,
    PhAwaitSecond
  } press_phase_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // tdata: [0] button_down, [StampW:1] time_us, zero padding above.
  logic [SampleW-1:0]           s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // tdata: [1:0] gesture, zero padding above.
  logic [bpc_pkg::OutW-1:0]     m_axis_tdata;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [bpc_pkg::AddrW-1:0]    paddr = '0;
  logic [bpc_pkg::DataW-1:0]    pwdata = '0;
  logic [bpc_pkg::DataW-1:0]    prdata;
  logic                         pready;

  // Predictor state and its copy of the threshold registers.
  press_phase_e                 press_phase = PhIdle;
  stamp_t                       press_at = '0;
  stamp_t                       release_at = '0;
  logic [bpc_pkg::MsW-1:0]      long_ms = bpc_pkg::LongPressMsReset;
  logic [bpc_pkg::MsW-1:0]      double_ms = bpc_pkg::DoublePressMsReset;

  sample_t                      sample_q[$];
  gesture_t                     gesture_q[$];
  sample_t                      next_sample;
  stamp_t                       clock_now = '0;
  int unsigned                  samples_made = 0;
  int unsigned                  samples_taken = 0;
  int unsigned                  fail_count = 0;
  int unsigned                  quiet_cycles = 0;
  int unsigned                  feed_gap = 0;
  int unsigned                  take_gap = 0;
  bit                           feed_calm = 1'b0;
  bit                           take_calm = 1'b0;
  bit                           sample_fire = 1'b0;
  bit                           result_fire = 1'b0;

  button_press_classifier_core #(
    .STAMP_BITS(StampW)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // True once the time since the stamp, taken modulo the stamp width, reaches the threshold.
  function automatic bit elapsed_reached(input stamp_t now, input stamp_t since,
                                         input logic [bpc_pkg::MsW-1:0] limit_ms);
    stamp_t span;
    span = now - since;
    return span >= stamp_t'(limit_ms) * stamp_t'(bpc_pkg::UsPerMs);
  endfunction

  // Advances the predictor by one accepted sample and queues the gesture it reports, if any.
  function automatic void predict_gesture(input logic down, input stamp_t now);
    case (press_phase)
      PhIdle: begin
        if (down) begin
          press_at    = now;
          press_phase = PhPressed;
        end
      end
      PhPressed: begin
        if (elapsed_reached(now, press_at, long_ms)) begin
          gesture_q.push_back(bpc_pkg::GestLong);
          press_phase = down ? PhHeld : PhIdle;
        end else if (!down) begin
          release_at  = now;
          press_phase = PhAwaitSecond;
        end
      end
      PhHeld: begin
        if (!down) begin
          press_phase = PhIdle;
        end
      end
      default: begin
        // Any press here is a double press; the window only runs out on released samples.
        if (down) begin
          gesture_q.push_back(bpc_pkg::GestDouble);
          press_phase = PhHeld;
        end else if (elapsed_reached(now, release_at, double_ms)) begin
          gesture_q.push_back(bpc_pkg::GestShort);
          press_phase = PhIdle;
        end
      end
    endcase
  endfunction

  function automatic void add_sample(input logic down, input stamp_t stamp);
    sample_q.push_back({down, stamp});
    samples_made++;
  endfunction

  // Time spans that favor the edges of a threshold given in microseconds.
  function automatic stamp_t near_limit(input stamp_t lim);
    case ($urandom_range(0, 7))
      0: return lim - 1;
      1: return lim;
      2: return lim + 1;
      3, 4: return stamp_t'($urandom_range(0, 32'(lim - 1)));
      5: return lim + stamp_t'($urandom_range(0, 32'(lim)));
      6: return stamp_t'($urandom_range(0, 20));
      default: return stamp_t'($urandom_range(32'(lim), 32'(lim) * 3));
    endcase
  endfunction

  // Stall length for one word; a calm stretch has no stalls at all.
  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Writes one threshold register and reads it back.
  task automatic cfg_set(input logic [bpc_pkg::AddrW-1:0] addr,
                         input logic [bpc_pkg::MsW-1:0] value);
    logic [bpc_pkg::DataW-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= bpc_pkg::DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == LongPressAddr) begin
      long_ms = value;
    end else begin
      double_ms = value;
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if (got !== bpc_pkg::DataW'(value)) begin
      $display("%0t: readback at address %0d, expected %0d, actual %0d",
               $time, addr, value, got);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every sample has been taken and every gesture has come out, then lets the
  // pipeline empty so that a register write cannot meet a sample in flight.
  task automatic settle();
    do @(negedge clk_i); while (samples_taken != samples_made || gesture_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Sample driver: one word at a time from the pending queue, with a drawn gap after each.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || sample_fire) begin
        if (feed_gap != 0) begin
          feed_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_sample = sample_q.pop_front();
          s_axis_tdata  <= SampleW'({next_sample.stamp, next_sample.down});
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            feed_calm = ~feed_calm;
          end
          feed_gap = draw_wait(feed_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: after each word taken, hold tready low for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_fire) begin
        if ($urandom_range(0, 39) == 0) begin
          take_calm = ~take_calm;
        end
        take_gap = draw_wait(take_calm);
      end
      if (take_gap != 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted sample, checks every accepted gesture in order, and
  // ends the run when neither stream moves for too long.
  always @(posedge clk_i) begin
    sample_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    result_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    if (sample_fire) begin
      predict_gesture(s_axis_tdata[0], s_axis_tdata[StampW:1]);
      samples_taken++;
    end
    if (result_fire) begin
      if (gesture_q.size() == 0) begin
        $display("%0t: gesture with none expected, expected none, actual %0d",
                 $time, m_axis_tdata[bpc_pkg::GestW-1:0]);
        fail_count++;
      end else if (m_axis_tdata[bpc_pkg::GestW-1:0] !== gesture_q[0]) begin
        $display("%0t: gesture mismatch, expected %0d, actual %0d",
                 $time, gesture_q[0], m_axis_tdata[bpc_pkg::GestW-1:0]);
        fail_count++;
        void'(gesture_q.pop_front());
      end else begin
        void'(gesture_q.pop_front());
      end
    end
    if (sample_fire || result_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    stamp_t                  lng;
    stamp_t                  dbl;
    stamp_t                  top;
    stamp_t                  hold;
    stamp_t                  pause;
    stamp_t                  t0;
    int unsigned             steps;
    logic [bpc_pkg::MsW-1:0] new_long;
    logic [bpc_pkg::MsW-1:0] new_double;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples under the reset thresholds of 1000 ms and 300 ms.
    lng = stamp_t'(long_ms) * stamp_t'(bpc_pkg::UsPerMs);
    dbl = stamp_t'(double_ms) * stamp_t'(bpc_pkg::UsPerMs);
    top = '1;
    add_sample(1'b0, stamp_t'(0));            // released while idle: nothing happens
    add_sample(1'b1, stamp_t'(0));
    add_sample(1'b1, lng - 1);                // one microsecond short of long
    add_sample(1'b1, lng);                    // long press while still held
    add_sample(1'b0, lng + 1);
    add_sample(1'b1, top);                    // press at the all-ones stamp
    add_sample(1'b0, lng - 2);                // wraps: held one microsecond short of long
    add_sample(1'b0, lng - 2 + dbl - 1);      // window not yet over
    add_sample(1'b0, lng - 2 + dbl);          // short press as the window runs out
    add_sample(1'b1, stamp_t'(5_000_000));
    add_sample(1'b0, stamp_t'(5_001_000));
    add_sample(1'b1, stamp_t'(9_000_000));    // late second press still counts as double
    add_sample(1'b1, stamp_t'(9_500_000));
    add_sample(1'b0, stamp_t'(9_600_000));
    add_sample(1'b1, stamp_t'(10_000_000));
    add_sample(1'b0, stamp_t'(11_000_000));   // long press reported at release
    add_sample(1'b1, stamp_t'(20_000_000));
    add_sample(1'b1, stamp_t'(19_999_999));   // time runs backwards: reads as a long hold
    add_sample(1'b0, stamp_t'(20_000_000));
    add_sample(1'b1, stamp_t'(30_000_000));
    add_sample(1'b0, stamp_t'(30_000_010));
    add_sample(1'b0, stamp_t'(30_000_010) + dbl - 1);
    add_sample(1'b1, stamp_t'(30_000_010) + dbl - 1);  // double press inside the window
    add_sample(1'b0, stamp_t'(30_500_000));
    add_sample(1'b0, top);
    settle();

    // Random gestures, one threshold setting per phase, the extremes first.
    clock_now = stamp_t'(40_000_000);
    for (int k = 0; k < 10; k++) begin
      case (k)
        0: begin
          new_long   = 16'd1;
          new_double = 16'd1;
        end
        1: begin
          new_long   = 16'hFFFF;
          new_double = 16'hFFFF;
        end
        2: begin
          new_long   = 16'd1;
          new_double = 16'hFFFF;
        end
        3: begin
          new_long   = 16'hFFFF;
          new_double = 16'd1;
        end
        4: begin
          new_long   = bpc_pkg::LongPressMsReset;
          new_double = bpc_pkg::DoublePressMsReset;
        end
        default: begin
          new_long   = 16'($urandom_range(1, (k < 8) ? 60 : 65535));
          new_double = 16'($urandom_range(1, (k < 8) ? 60 : 65535));
        end
      endcase
      cfg_set(LongPressAddr, new_long);
      cfg_set(DoublePressAddr, new_double);
      lng = stamp_t'(long_ms) * stamp_t'(bpc_pkg::UsPerMs);
      dbl = stamp_t'(double_ms) * stamp_t'(bpc_pkg::UsPerMs);

      while (sample_q.size() < PhaseSamples) begin
        // Now and then jump the timestamp anywhere, or just below the wrap, or add line noise.
        case ($urandom_range(0, 15))
          0: clock_now = stamp_t'({$urandom, $urandom});
          1: clock_now = stamp_t'(0) - stamp_t'($urandom_range(1, 32'(lng)));
          2: begin
            repeat ($urandom_range(1, 6)) begin
              clock_now = clock_now + stamp_t'($urandom_range(0, 32'(lng)))
                          - stamp_t'($urandom_range(0, 2000));
              add_sample(1'($urandom_range(0, 1)), clock_now);
            end
          end
          default: ;
        endcase

        // Press, a few held samples spread over the hold, then the release.
        t0   = clock_now;
        hold = near_limit(lng);
        add_sample(1'b1, t0);
        steps = $urandom_range(0, 3);
        for (int unsigned i = 1; i <= steps; i++) begin
          add_sample(1'b1, t0 + hold * i / (steps + 1));
        end
        if ($urandom_range(0, 11) == 0) begin
          // Broken gesture: the release never comes before the next press.
          clock_now = t0 + hold;
        end else begin
          t0 = t0 + hold;
          add_sample(1'b0, t0);
          pause = near_limit(dbl);
          steps = $urandom_range(0, 2);
          for (int unsigned i = 1; i <= steps; i++) begin
            add_sample(1'b0, t0 + pause * i / (steps + 1));
          end
          if ($urandom_range(0, 1) == 1) begin
            // Second press at the edge of the window, then its own release.
            add_sample(1'b1, t0 + pause);
            t0 = t0 + pause + near_limit(lng);
            add_sample(1'b0, t0);
          end else begin
            t0 = t0 + pause;
            add_sample(1'b0, t0);
          end
          clock_now = t0 + near_limit(dbl);
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
